@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the deframer checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/lpfd_pkg.sv @@
// Package with section codes, header sizes and shared types of the deframer.
package lpfd_pkg;

    localparam int SEC_W = 3;
    localparam int LEN_W = 32;

    localparam logic [SEC_W-1:0] SEC_TOPIC_LEN = 3'd0;
    localparam logic [SEC_W-1:0] SEC_TOPIC     = 3'd1;
    localparam logic [SEC_W-1:0] SEC_NAME_LEN  = 3'd2;
    localparam logic [SEC_W-1:0] SEC_NAME      = 3'd3;
    localparam logic [SEC_W-1:0] SEC_DATA_LEN  = 3'd4;
    localparam logic [SEC_W-1:0] SEC_DATA      = 3'd5;

    localparam int SHORT_HDR_BYTES = 2;
    localparam int LONG_HDR_BYTES  = 4;

    // Index of the final byte within each header kind.
    localparam logic [1:0] SHORT_HDR_LAST = 2'(SHORT_HDR_BYTES - 1);
    localparam logic [1:0] LONG_HDR_LAST  = 2'(LONG_HDR_BYTES - 1);

    // Widths of the output tuser and tdata words and bit positions inside tuser.
    localparam int TUSER_W        = 4;
    localparam int TUSER_SEC_LAST = 3;
    localparam int TDATA_W        = 40;

    typedef struct packed {
        logic [SEC_W-1:0] section;
        logic             section_last;
        logic             frame_end;
        logic [LEN_W-1:0] length_value;
    } t_step_result;

endpackage

@@ rtl/core/lpfd_section_fsm.sv @@
// Section tracker: holds the frame parsing state and tags one byte per enable.
module lpfd_section_fsm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output lpfd_pkg::t_step_result o_result
);
    import lpfd_pkg::*;

    logic [SEC_W-1:0] r_section, n_section;
    logic [1:0]       r_hdr_idx, n_hdr_idx;
    logic [LEN_W-1:0] r_acc, n_acc;
    logic [LEN_W-1:0] r_remaining, n_remaining;

    logic [SEC_W-1:0] sec;
    logic             is_hdr;
    logic             hdr_last;
    logic [LEN_W-1:0] acc;

    always_comb begin
        // Codes past the data section fall back to the topic length header.
        sec = (r_section > SEC_DATA) ? SEC_TOPIC_LEN : r_section;
        is_hdr = (sec == SEC_TOPIC_LEN) || (sec == SEC_NAME_LEN) || (sec == SEC_DATA_LEN);
        hdr_last = (sec == SEC_DATA_LEN) ? (r_hdr_idx >= LONG_HDR_LAST)
                                         : (r_hdr_idx >= SHORT_HDR_LAST);
        acc = {r_acc[LEN_W-9:0], i_byte};

        n_section   = sec;
        n_hdr_idx   = r_hdr_idx;
        n_acc       = r_acc;
        n_remaining = r_remaining;
        o_result.section      = sec;
        o_result.section_last = 1'b0;
        o_result.frame_end    = 1'b0;
        o_result.length_value = '0;

        if (is_hdr) begin
            if (hdr_last) begin
                o_result.section_last = 1'b1;
                o_result.length_value = acc;
                n_hdr_idx = '0;
                n_acc     = '0;
                if (acc == '0) begin
                    // An empty body is skipped; an empty data body closes the frame.
                    n_remaining = '0;
                    if (sec == SEC_DATA_LEN) begin
                        o_result.frame_end = 1'b1;
                        n_section = SEC_TOPIC_LEN;
                    end else begin
                        n_section = sec + SEC_W'(2);
                    end
                end else begin
                    n_remaining = acc;
                    n_section   = sec + SEC_W'(1);
                end
            end else begin
                n_hdr_idx = r_hdr_idx + 2'd1;
                n_acc     = acc;
            end
        end else begin
            if (r_remaining <= LEN_W'(1)) begin
                o_result.section_last = 1'b1;
                n_remaining = '0;
                n_hdr_idx   = '0;
                n_acc       = '0;
                if (sec == SEC_DATA) begin
                    o_result.frame_end = 1'b1;
                    n_section = SEC_TOPIC_LEN;
                end else begin
                    n_section = sec + SEC_W'(1);
                end
            end else begin
                n_remaining = r_remaining - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section   <= SEC_TOPIC_LEN;
            r_hdr_idx   <= '0;
            r_acc       <= '0;
            r_remaining <= '0;
        end else if (i_step) begin
            r_section   <= n_section;
            r_hdr_idx   <= n_hdr_idx;
            r_acc       <= n_acc;
            r_remaining <= n_remaining;
        end
    end

endmodule

@@ rtl/core/length_prefixed_frame_deframer_core.sv @@
// Length-prefixed frame deframer: tags each byte of a received stream with its section.
// Each frame carries a 2-byte topic length, the topic, a 2-byte name length, the name,
// a 4-byte data length and the data, all lengths big-endian. One byte is taken per cycle
// unless the output stalls with the input register full. The byte is held in an input
// register, then the section tracker updates its state and fills the result register.
// A stalled output holds the result while one more byte may wait in the
// input register. tlast marks the last byte of a frame, tuser carries the section code
// and a section-last flag, and the upper tdata bits carry the decoded length on the last
// byte of each length header (zero elsewhere).
module length_prefixed_frame_deframer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [lpfd_pkg::TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [39:8] length_value
    output logic                         m_axis_tlast,   // frame_end
    output logic [lpfd_pkg::TUSER_W-1:0] m_axis_tuser    // [2:0] section, [3] section_last
);
    import lpfd_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_out_valid;
    logic [7:0]   r_out_byte;
    t_step_result r_out_res;

    logic         advance;
    logic         step;
    t_step_result res;

    // The result register can take a new request when empty or being drained.
    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    lpfd_section_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (step) begin
            r_out_byte <= r_in_byte;
            r_out_res  <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_res.length_value, r_out_byte};
    assign m_axis_tlast  = r_out_res.frame_end;
    assign m_axis_tuser  = {r_out_res.section_last, r_out_res.section};

endmodule

@@ rtl/core/lpfd_checker.sv @@
// Port-level checker for the deframer, bound to the top level.
`include "assert_macros.svh"

module lpfd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [lpfd_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                         m_axis_tlast,
    input logic [lpfd_pkg::TUSER_W-1:0] m_axis_tuser
);
    import lpfd_pkg::*;

    logic [SEC_W-1:0]         sec;
    logic                     sec_last;
    logic                     out_stall;
    logic                     len_nonzero;
    logic                     hdr_sec;
    logic                     end_sec;
    logic [TDATA_W+TUSER_W:0] out_word;

    assign sec         = m_axis_tuser[SEC_W-1:0];
    assign sec_last    = m_axis_tuser[TUSER_SEC_LAST];
    assign out_stall   = i_rst_n && m_axis_tvalid && !m_axis_tready;
    assign len_nonzero = m_axis_tdata[TDATA_W-1:8] != '0;
    assign hdr_sec     = (sec == SEC_TOPIC_LEN) || (sec == SEC_NAME_LEN) || (sec == SEC_DATA_LEN);
    assign end_sec     = (sec == SEC_DATA_LEN) || (sec == SEC_DATA);
    assign out_word    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    // A stalled result holds its payload.
    `ASSERT_IMPLY(a_hold, i_clk, i_rst_n, $past(out_stall), m_axis_tvalid && $stable(out_word))
    // A frame only ends on the last byte of the data length header or of the data.
    `ASSERT_IMPLY(a_end_sec, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, sec_last && end_sec)
    // A length is reported only on the final byte of a length header.
    `ASSERT_IMPLY(a_len_hdr, i_clk, i_rst_n, m_axis_tvalid && len_nonzero, sec_last && hdr_sec)
    // Output sections never use the spare codes.
    `ASSERT_IMPLY(a_sec_range, i_clk, i_rst_n, m_axis_tvalid, sec <= SEC_DATA)
    // Reset empties the pipeline, so no result follows a reset cycle.
    `ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind length_prefixed_frame_deframer_core lpfd_checker u_lpfd_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the length-prefixed frame deframer core.
`timescale 1ns / 100ps

module tb;
    import lpfd_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct {
        logic [7:0]       data;
        logic [SEC_W-1:0] section;
        logic             section_last;
        logic             frame_end;
        logic [LEN_W-1:0] length_value;
    } t_tagged_byte;

    // Tracks the section of each byte and keeps the tagged bytes still to come out.
    class deframe_scoreboard;
        logic [SEC_W-1:0] cur_sec;
        logic [1:0]       hdr_idx;
        logic [LEN_W-1:0] len_acc;
        logic [LEN_W-1:0] body_left;
        t_tagged_byte     tagged_q[$];
        int               errors;

        function new();
            cur_sec   = SEC_TOPIC_LEN;
            hdr_idx   = '0;
            len_acc   = '0;
            body_left = '0;
            errors    = 0;
        endfunction

        function t_tagged_byte tag_byte(logic [7:0] b);
            t_tagged_byte     r;
            logic [SEC_W-1:0] sec;
            logic [LEN_W-1:0] acc;
            int               hdr_size;
            sec = cur_sec;
            if (sec > SEC_DATA) sec = SEC_TOPIC_LEN;
            r.data         = b;
            r.section      = sec;
            r.section_last = 1'b0;
            r.frame_end    = 1'b0;
            r.length_value = '0;
            if (sec == SEC_TOPIC_LEN || sec == SEC_NAME_LEN || sec == SEC_DATA_LEN) begin
                hdr_size = (sec == SEC_DATA_LEN) ? LONG_HDR_BYTES : SHORT_HDR_BYTES;
                acc = {len_acc[LEN_W-9:0], b};
                if (int'(hdr_idx) + 1 >= hdr_size) begin
                    r.section_last = 1'b1;
                    r.length_value = acc;
                    hdr_idx = '0;
                    len_acc = '0;
                    if (acc == '0) begin
                        // An empty body is skipped; an empty data section ends the frame.
                        if (sec == SEC_DATA_LEN) begin
                            r.frame_end = 1'b1;
                            cur_sec = SEC_TOPIC_LEN;
                        end else begin
                            cur_sec = sec + 3'd2;
                        end
                        body_left = '0;
                    end else begin
                        body_left = acc;
                        cur_sec = sec + 3'd1;
                    end
                end else begin
                    hdr_idx = hdr_idx + 2'd1;
                    len_acc = acc;
                    cur_sec = sec;
                end
            end else begin
                if (body_left <= 1) begin
                    body_left = '0;
                    r.section_last = 1'b1;
                    if (sec == SEC_DATA) begin
                        r.frame_end = 1'b1;
                        cur_sec = SEC_TOPIC_LEN;
                    end else begin
                        cur_sec = sec + 3'd1;
                    end
                    hdr_idx = '0;
                    len_acc = '0;
                end else begin
                    body_left = body_left - 1;
                    cur_sec = sec;
                end
            end
            return r;
        endfunction

        function void note_request(logic [7:0] b);
            tagged_q.push_back(tag_byte(b));
        endfunction

        function void check_result(logic [7:0] data, logic [SEC_W-1:0] sec, logic sec_last,
                                   logic fend, logic [LEN_W-1:0] lenv);
            t_tagged_byte e;
            if (tagged_q.size() == 0) begin
                $display("%0t: unexpected result data=%h section=%0d", $time, data, sec);
                errors++;
                return;
            end
            e = tagged_q.pop_front();
            if (data !== e.data) begin
                $display("%0t: out_byte expected %h actual %h", $time, e.data, data);
                errors++;
            end
            if (sec !== e.section) begin
                $display("%0t: section expected %0d actual %0d", $time, e.section, sec);
                errors++;
            end
            if (sec_last !== e.section_last) begin
                $display("%0t: section_last expected %b actual %b", $time, e.section_last,
                         sec_last);
                errors++;
            end
            if (fend !== e.frame_end) begin
                $display("%0t: frame_end expected %b actual %b", $time, e.frame_end, fend);
                errors++;
            end
            if (lenv !== e.length_value) begin
                $display("%0t: length_value expected %h actual %h", $time, e.length_value,
                         lenv);
                errors++;
            end
        endfunction

        function int pending();
            return tagged_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;    // [7:0] rx_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;            // [7:0] out_byte, [39:8] length_value
    logic                 m_axis_tlast;            // frame_end
    logic [TUSER_W-1:0]   m_axis_tuser;            // [2:0] section, [3] section_last

    deframe_scoreboard    sb = new();
    deframe_scoreboard    stream_plan = new();
    logic [7:0]           stream_q[$];
    int                   requests_taken = 0;
    int                   idle_cycles = 0;

    length_prefixed_frame_deframer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // The planning copy of the tracker lets the generator know where the stream stands.
    function automatic void emit(logic [7:0] b);
        t_tagged_byte unused;
        stream_q.push_back(b);
        unused = stream_plan.tag_byte(b);
    endfunction

    function automatic void emit_frame(int unsigned tl, int unsigned nl, int unsigned dl,
                                       int unsigned cut);
        logic [7:0] fq[$];
        fq.push_back(tl[15:8]);
        fq.push_back(tl[7:0]);
        repeat (tl) fq.push_back(8'($urandom));
        fq.push_back(nl[15:8]);
        fq.push_back(nl[7:0]);
        repeat (nl) fq.push_back(8'($urandom));
        fq.push_back(dl[31:24]);
        fq.push_back(dl[23:16]);
        fq.push_back(dl[15:8]);
        fq.push_back(dl[7:0]);
        repeat (dl) fq.push_back(8'($urandom));
        foreach (fq[i]) begin
            if (i < cut) emit(fq[i]);
        end
    endfunction

    // Random bytes that keep every length header begun here below 256 so the stream soon realigns.
    function automatic void emit_safe(int unsigned n, bit to_boundary);
        int hdr_size;
        while (n > 0 || (to_boundary && !(stream_plan.cur_sec == SEC_TOPIC_LEN &&
                                          stream_plan.hdr_idx == 0))) begin
            if (stream_plan.cur_sec == SEC_TOPIC || stream_plan.cur_sec == SEC_NAME ||
                stream_plan.cur_sec == SEC_DATA) begin
                emit(8'($urandom));
            end else begin
                hdr_size = (stream_plan.cur_sec == SEC_DATA_LEN) ? LONG_HDR_BYTES
                                                                 : SHORT_HDR_BYTES;
                if (int'(stream_plan.hdr_idx) + 1 >= hdr_size)
                    emit(to_boundary ? 8'($urandom_range(0, 3)) : 8'($urandom));
                else
                    emit(8'h00);
            end
            if (n > 0) n--;
        end
    endfunction

    function automatic void build_stream();
        int unsigned tl, nl, dl, total, start;
        int          kind;
        // Frame with every length zero: empty topic, empty name, empty data.
        emit_frame(0, 0, 0, 1000);
        // One byte in each body, carrying both extremes of a byte.
        emit(8'h00); emit(8'h01); emit(8'hFF);
        emit(8'h00); emit(8'h01); emit(8'h00);
        emit(8'h00); emit(8'h00); emit(8'h00); emit(8'h01); emit(8'h80);
        // Bodies present only in the topic and data sections.
        emit(8'h00); emit(8'h02); emit(8'h7F); emit(8'hAA);
        emit(8'h00); emit(8'h00);
        emit(8'h00); emit(8'h00); emit(8'h00); emit(8'h01); emit(8'h55);
        start = stream_q.size();
        while (stream_q.size() - start < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            tl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            nl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0)
                dl = $urandom_range(100, 260);
            else
                dl = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            total = 8 + tl + nl + dl;
            if (kind < 80) begin
                emit_frame(tl, nl, dl, total);
            end else if (kind < 90) begin
                // A frame that stops short, then filler until the next frame boundary.
                emit_frame(tl, nl, dl, $urandom_range(1, total - 1));
                emit_safe(0, 1'b1);
            end else begin
                emit_safe($urandom_range(1, 8), 1'b0);
                emit_safe(0, 1'b1);
            end
        end
        // The largest data length; the frame stays open until the end of the run.
        emit(8'h00); emit(8'h00); emit(8'h00); emit(8'h00);
        emit(8'hFF); emit(8'hFF); emit(8'hFF); emit(8'hFF);
        repeat (4) emit(8'($urandom));
    endfunction

    task automatic send_stream();
        int burst;
        int gap;
        while (stream_q.size() > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && stream_q.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= stream_q.pop_front();
                do @(posedge i_clk); while (!s_axis_tready);
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic run_receiver();
        int  mode;
        int  span;
        bit  held = 1'b0;
        logic rdy;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span) begin
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = ($urandom_range(0, 7) != 0);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
                m_axis_tready <= rdy;
            end
            if (!held && requests_taken > 100) begin
                // Long hold-off so the block fills up and pushes back on its input.
                held = 1'b1;
                @(posedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_request(s_axis_tdata);
            requests_taken <= requests_taken + 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[7:0], m_axis_tuser[SEC_W-1:0],
                            m_axis_tuser[TUSER_SEC_LAST], m_axis_tlast,
                            m_axis_tdata[8 +: LEN_W]);
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        build_stream();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            run_receiver();
        join_none
        send_stream();
        // Let the monitor note the final request before counting what is pending.
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/lpfd_pkg.sv
rtl/core/lpfd_section_fsm.sv
rtl/core/length_prefixed_frame_deframer_core.sv
rtl/core/lpfd_checker.sv
sim/tb.sv
